// File: rtl/pbte_pkg.sv
// shared types, codes and fixed point helpers of the piecewise basis table evaluator
// no dependencies
package pbte_pkg;

    localparam int FRAC_BITS        = 28;
    localparam int SEGMENTS_DEFAULT = 64;
    localparam int Q_W              = 32;
    localparam int CFG_ADDR_W       = 5;

    typedef logic signed [Q_W-1:0] q_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_VALUE = 2'd1,
        OP_DER1  = 2'd2,
        OP_DER2  = 2'd3
    } op_t;

    localparam logic [2:0] SEL_COEF_LAST = 3'd4;
    localparam logic [2:0] SEL_CUMUL     = 3'd5;

    localparam logic [2:0] REG_START     = 3'd0;
    localparam logic [2:0] REG_INV_SPAN  = 3'd1;
    localparam logic [2:0] REG_SEG_COUNT = 3'd2;
    localparam logic [2:0] REG_SEG_WIDTH = 3'd3;
    localparam logic [2:0] REG_VAL_SCALE = 3'd4;
    localparam logic [2:0] REG_D1_SCALE  = 3'd5;
    localparam logic [2:0] REG_D2_SCALE  = 3'd6;

    localparam q_t Q_ONE  = q_t'(64'sd1 <<< FRAC_BITS);
    localparam q_t Q_HALF = q_t'(64'sd1 <<< (FRAC_BITS - 1));

    function automatic q_t sat64(input logic signed [63:0] v);
        q_t r;
        if (v > 64'sd2147483647)
            r = q_t'(32'h7fff_ffff);
        else if (v < -64'sd2147483648)
            r = q_t'(32'h8000_0000);
        else
            r = q_t'(v[31:0]);
        return r;
    endfunction

    // exact product, round half up, saturate
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] ae;
        logic signed [63:0] be;
        logic signed [63:0] p;
        ae = a;
        be = b;
        p  = ae * be + (64'sd1 <<< (FRAC_BITS - 1));
        return sat64(p >>> FRAC_BITS);
    endfunction

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [63:0] s;
        logic signed [63:0] ae;
        logic signed [63:0] be;
        ae = a;
        be = b;
        s  = ae + be;
        return sat64(s);
    endfunction

    function automatic q_t sat_sub(input q_t a, input q_t b);
        logic signed [63:0] s;
        logic signed [63:0] ae;
        logic signed [63:0] be;
        ae = a;
        be = b;
        s  = ae - be;
        return sat64(s);
    endfunction

    // divisions truncate toward zero
    function automatic q_t div2(input q_t a);
        logic signed [32:0] t;
        t = {a[31], a} + {32'd0, a[31]};
        return q_t'(t >>> 1);
    endfunction

    function automatic q_t div4(input q_t a);
        logic signed [32:0] t;
        t = {a[31], a} + {31'd0, a[31], a[31]};
        return q_t'(t >>> 2);
    endfunction

    // reciprocal multiply, exact for every 32 bit magnitude
    function automatic q_t div3(input q_t a);
        logic [31:0] mag;
        logic [64:0] p;
        logic [31:0] q;
        mag = a[31] ? (32'd0 - a) : a;
        p   = {33'd0, mag} * {32'd0, 33'h0_aaaa_aaab};
        q   = p[64:33];
        return a[31] ? q_t'(32'd0 - q) : q_t'(q);
    endfunction

    function automatic q_t times2(input q_t a);
        logic signed [63:0] ae;
        ae = a;
        return sat64(ae * 64'sd2);
    endfunction

    function automatic q_t times3(input q_t a);
        logic signed [63:0] ae;
        ae = a;
        return sat64(ae * 64'sd3);
    endfunction

endpackage

// File: rtl/piecewise_basis_table_evaluator_top.sv
// Piecewise basis table evaluator. One item is taken every clock cycle (busy stays low);
// an evaluation gives its result and clamped flag on done after it passes through the
// arithmetic pipeline (parameter map, segment split, table read, horner steps, final
// scale). Table writes give no result and take effect for every item taken after them.
// Table entries that were never written read as garbage.
// Depends on pbte_pkg, pbte_ram and pbte_mac_stage.
module piecewise_basis_table_evaluator_top #(
    parameter int SEGMENTS = pbte_pkg::SEGMENTS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbte_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        opcode,
    input  logic [2:0]                        table_select,
    input  logic [6:0]                        table_index,
    input  logic signed [31:0]                table_word,
    input  logic signed [31:0]                param,
    output logic                              done,
    output logic signed [31:0]                result,
    output logic                              clamped
);
    import pbte_pkg::*;

    localparam int K_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int B_W    = $clog2(SEGMENTS + 1);
    localparam int M_W    = $clog2(SEGMENTS + 1);
    localparam int P_W    = Q_W + M_W + 1;
    localparam int KW_W   = K_W + 29;
    localparam int D_W    = ((KW_W + 1 > Q_W) ? KW_W + 1 : Q_W) + 1;
    localparam int U_W    = D_W + M_W + 1;

    // configuration registers
    q_t          start_param_reg;
    q_t          inv_span_reg;
    logic [6:0]  segment_count_reg;
    logic [28:0] segment_width_reg;
    q_t          value_scale_reg;
    q_t          der1_scale_reg;
    q_t          der2_scale_reg;

    logic        cfg_write;
    logic [2:0]  cfg_sel;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_param_reg   <= '0;
            inv_span_reg      <= Q_ONE;
            segment_count_reg <= 7'd64;
            segment_width_reg <= 29'd4194304;
            value_scale_reg   <= Q_ONE;
            der1_scale_reg    <= Q_ONE;
            der2_scale_reg    <= Q_ONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_START:     start_param_reg   <= q_t'(pwdata);
                REG_INV_SPAN:  inv_span_reg      <= q_t'(pwdata);
                REG_SEG_COUNT: segment_count_reg <= pwdata[6:0];
                REG_SEG_WIDTH: segment_width_reg <= pwdata[28:0];
                REG_VAL_SCALE: value_scale_reg   <= q_t'(pwdata);
                REG_D1_SCALE:  der1_scale_reg    <= q_t'(pwdata);
                REG_D2_SCALE:  der2_scale_reg    <= q_t'(pwdata);
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_START:     prdata = start_param_reg;
            REG_INV_SPAN:  prdata = inv_span_reg;
            REG_SEG_COUNT: prdata = {25'd0, segment_count_reg};
            REG_SEG_WIDTH: prdata = {3'd0, segment_width_reg};
            REG_VAL_SCALE: prdata = value_scale_reg;
            REG_D1_SCALE:  prdata = der1_scale_reg;
            REG_D2_SCALE:  prdata = der2_scale_reg;
            default:       prdata = '0;
        endcase
    end

    // effective segment count
    logic [M_W-1:0] m;
    logic [M_W-1:0] m_last;
    q_t             w_q;

    always_comb
    begin
        if (segment_count_reg == 7'd0)
            m = M_W'(1);
        else if (32'(segment_count_reg) > 32'(SEGMENTS))
            m = M_W'(SEGMENTS);
        else
            m = M_W'(segment_count_reg);
    end

    assign m_last = m - M_W'(1);
    assign w_q    = q_t'({3'd0, segment_width_reg});

    // stage 1: accepted beat
    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [2:0]  s1_sel_reg;
    logic [6:0]  s1_idx_reg;
    q_t          s1_word_reg;
    q_t          s1_t_reg;

    // stage 2: t - start
    logic        s2_valid_reg;
    op_t         s2_op_reg;
    logic [2:0]  s2_sel_reg;
    logic [6:0]  s2_idx_reg;
    q_t          s2_word_reg;
    q_t          s2_d_reg;

    // stage 3: raw product with inv_span
    logic               s3_valid_reg;
    op_t                s3_op_reg;
    logic [2:0]         s3_sel_reg;
    logic [6:0]         s3_idx_reg;
    q_t                 s3_word_reg;
    logic signed [63:0] s3_p_reg;

    // stage 4: x
    logic        s4_valid_reg;
    op_t         s4_op_reg;
    logic [2:0]  s4_sel_reg;
    logic [6:0]  s4_idx_reg;
    q_t          s4_word_reg;
    q_t          s4_x_reg;

    // stage 5: x * m
    logic                  s5_valid_reg;
    op_t                   s5_op_reg;
    logic [2:0]            s5_sel_reg;
    logic [6:0]            s5_idx_reg;
    q_t                    s5_word_reg;
    q_t                    s5_x_reg;
    logic signed [P_W-1:0] s5_prod_reg;

    // stage 6: segment index
    logic           s6_valid_reg;
    op_t            s6_op_reg;
    logic [2:0]     s6_sel_reg;
    logic [6:0]     s6_idx_reg;
    q_t             s6_word_reg;
    q_t             s6_x_reg;
    logic [K_W-1:0] s6_k_reg;
    logic           s6_cl_reg;

    // stage 7: k * w, table read in flight
    logic            s7_valid_reg;
    op_t             s7_op_reg;
    q_t              s7_x_reg;
    logic [KW_W-1:0] s7_kw_reg;
    logic            s7_cl_reg;

    // stage 8: local fraction and coefficient set
    logic s8_valid_reg;
    op_t  s8_op_reg;
    logic s8_cl_reg;
    q_t   s8_u_reg;
    q_t   s8_c3_reg;
    q_t   s8_c2_reg;
    q_t   s8_c1_reg;
    q_t   s8_a0_reg;
    q_t   s8_a4_reg;
    q_t   s8_bk_reg;
    q_t   s8_bk1_reg;

    // stages 9..11: horner
    logic s9_valid_reg;
    op_t  s9_op_reg;
    logic s9_cl_reg;
    q_t   s9_u_reg;
    q_t   s9_c1_reg;
    q_t   s9_a0_reg;
    q_t   s9_a4_reg;
    q_t   s9_bk_reg;
    q_t   s9_bk1_reg;
    q_t   s9_wu_reg;
    q_t   s9_h1;

    logic s10_valid_reg;
    op_t  s10_op_reg;
    logic s10_cl_reg;
    q_t   s10_u_reg;
    q_t   s10_a0_reg;
    q_t   s10_a4_reg;
    q_t   s10_bk_reg;
    q_t   s10_bk1_reg;
    q_t   s10_wu_reg;
    q_t   s10_h2;

    logic s11_valid_reg;
    op_t  s11_op_reg;
    logic s11_cl_reg;
    q_t   s11_u_reg;
    q_t   s11_a4_reg;
    q_t   s11_bk_reg;
    q_t   s11_bk1_reg;
    q_t   s11_wu_reg;
    q_t   s11_h2_reg;
    q_t   s11_h3;

    // stage 12..13: integral tail
    logic s12_valid_reg;
    op_t  s12_op_reg;
    logic s12_cl_reg;
    logic s12_high_reg;
    q_t   s12_bk1_reg;
    q_t   s12_r1_reg;

    logic s13_valid_reg;
    op_t  s13_op_reg;
    logic s13_cl_reg;
    q_t   s13_r2_reg;

    // stage 14: output register
    logic done_reg;
    q_t   result_reg;
    logic clamped_reg;

    // stage 6 comb: truncate toward zero and clamp
    logic signed [P_W-1:0] q_floor;
    logic signed [P_W-1:0] q_trunc;
    logic signed [P_W-1:0] q_last;
    logic [K_W-1:0]        k_next;
    logic                  cl_next;

    always_comb
    begin
        q_floor = s5_prod_reg >>> FRAC_BITS;
        q_trunc = q_floor;
        if (s5_prod_reg[P_W-1] && (|s5_prod_reg[FRAC_BITS-1:0]))
            q_trunc = q_floor + P_W'(1);
        q_last  = $signed({{(P_W - M_W){1'b0}}, m_last});
        k_next  = q_trunc[K_W-1:0];
        cl_next = 1'b0;
        priority if (q_trunc < 0)
        begin
            k_next  = '0;
            cl_next = 1'b1;
        end
        else if (q_trunc > q_last)
        begin
            k_next  = m_last[K_W-1:0];
            cl_next = 1'b1;
        end
    end

    // table writes happen in stage 6, where reads are issued, to keep item order
    logic [31:0]    wr_idx;
    logic           wr_beat;
    logic           wr_coef;
    logic           wr_cumul;
    logic [B_W-1:0] rd_b1_addr;
    logic [31:0]    coef_rd [5];
    logic [31:0]    cumul_rd0;
    logic [31:0]    cumul_rd1;

    assign wr_idx     = {25'd0, s6_idx_reg};
    assign wr_beat    = s6_valid_reg && (s6_op_reg == OP_WRITE);
    assign wr_coef    = wr_beat && (s6_sel_reg <= SEL_COEF_LAST) && (wr_idx < 32'(SEGMENTS));
    assign wr_cumul   = wr_beat && (s6_sel_reg == SEL_CUMUL) && (wr_idx <= 32'(SEGMENTS));
    assign rd_b1_addr = B_W'(s6_k_reg) + B_W'(1);

    for (genvar j = 0; j < 5; j++)
    begin : g_coef
        pbte_ram #(
            .WIDTH (Q_W),
            .DEPTH (SEGMENTS)
        ) u_coef_ram (
            .clk   (clk),
            .we    (wr_coef && (s6_sel_reg == 3'(j))),
            .waddr (wr_idx[K_W-1:0]),
            .wdata (s6_word_reg),
            .raddr (s6_k_reg),
            .rdata (coef_rd[j])
        );
    end

    // two copies of the cumulative store so k and k+1 read together
    pbte_ram #(
        .WIDTH (Q_W),
        .DEPTH (SEGMENTS + 1)
    ) u_cumul_ram0 (
        .clk   (clk),
        .we    (wr_cumul),
        .waddr (wr_idx[B_W-1:0]),
        .wdata (s6_word_reg),
        .raddr (B_W'(s6_k_reg)),
        .rdata (cumul_rd0)
    );

    pbte_ram #(
        .WIDTH (Q_W),
        .DEPTH (SEGMENTS + 1)
    ) u_cumul_ram1 (
        .clk   (clk),
        .we    (wr_cumul),
        .waddr (wr_idx[B_W-1:0]),
        .wdata (s6_word_reg),
        .raddr (rd_b1_addr),
        .rdata (cumul_rd1)
    );

    // stage 8 comb: u = sat((x - k*w) * m), coefficient forms per request
    logic signed [D_W-1:0] diff;
    logic signed [U_W-1:0] u_wide;
    logic signed [63:0]    u_64;
    q_t                    u_next;
    q_t                    c3_next;
    q_t                    c2_next;
    q_t                    c1_next;

    always_comb
    begin
        diff   = $signed({{(D_W - Q_W){s7_x_reg[Q_W-1]}}, s7_x_reg})
               - $signed({{(D_W - KW_W){1'b0}}, s7_kw_reg});
        u_wide = diff * $signed({1'b0, m});
        u_64   = u_wide;
        u_next = sat64(u_64);
        unique case (s7_op_reg)
            OP_VALUE:
            begin
                c3_next = div4(q_t'(coef_rd[3]));
                c2_next = div3(q_t'(coef_rd[2]));
                c1_next = div2(q_t'(coef_rd[1]));
            end
            OP_DER2:
            begin
                c3_next = times3(q_t'(coef_rd[3]));
                c2_next = times2(q_t'(coef_rd[2]));
                c1_next = q_t'(coef_rd[1]);
            end
            default:
            begin
                c3_next = q_t'(coef_rd[3]);
                c2_next = q_t'(coef_rd[2]);
                c1_next = q_t'(coef_rd[1]);
            end
        endcase
    end

    // horner steps
    pbte_mac_stage u_mac1 (
        .clk (clk),
        .a   (s8_u_reg),
        .b   (s8_c3_reg),
        .c   (s8_c2_reg),
        .sum (s9_h1)
    );

    pbte_mac_stage u_mac2 (
        .clk (clk),
        .a   (s9_u_reg),
        .b   (s9_h1),
        .c   (s9_c1_reg),
        .sum (s10_h2)
    );

    pbte_mac_stage u_mac3 (
        .clk (clk),
        .a   (s10_u_reg),
        .b   (s10_h2),
        .c   (s10_a0_reg),
        .sum (s11_h3)
    );

    // stage 12 comb
    logic high_next;
    q_t   r1_next;

    always_comb
    begin
        high_next = (s11_u_reg > Q_HALF);
        unique case (s11_op_reg)
            OP_VALUE:
            begin
                if (high_next)
                    r1_next = sat_sub(s11_a4_reg, qmul(s11_u_reg, s11_h3));
                else
                    r1_next = sat_add(s11_bk_reg, qmul(s11_wu_reg, s11_h3));
            end
            OP_DER2:  r1_next = s11_h2_reg;
            default:  r1_next = s11_h3;
        endcase
    end

    // stage 13 and 14 comb
    q_t r2_next;
    q_t scale;

    always_comb
    begin
        if ((s12_op_reg == OP_VALUE) && s12_high_reg)
            r2_next = sat_sub(s12_bk1_reg, qmul(w_q, s12_r1_reg));
        else
            r2_next = s12_r1_reg;
        unique case (s13_op_reg)
            OP_VALUE: scale = value_scale_reg;
            OP_DER1:  scale = der1_scale_reg;
            default:  scale = der2_scale_reg;
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= start;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            s11_valid_reg <= s10_valid_reg;
            s12_valid_reg <= s11_valid_reg;
            s13_valid_reg <= s12_valid_reg;
            done_reg      <= s13_valid_reg && (s13_op_reg != OP_WRITE);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        s1_op_reg   <= op_t'(opcode);
        s1_sel_reg  <= table_select;
        s1_idx_reg  <= table_index;
        s1_word_reg <= table_word;
        s1_t_reg    <= param;

        s2_op_reg   <= s1_op_reg;
        s2_sel_reg  <= s1_sel_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_word_reg <= s1_word_reg;
        s2_d_reg    <= sat_sub(s1_t_reg, start_param_reg);

        s3_op_reg   <= s2_op_reg;
        s3_sel_reg  <= s2_sel_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_word_reg <= s2_word_reg;
        s3_p_reg    <= 64'(s2_d_reg) * 64'(inv_span_reg);

        s4_op_reg   <= s3_op_reg;
        s4_sel_reg  <= s3_sel_reg;
        s4_idx_reg  <= s3_idx_reg;
        s4_word_reg <= s3_word_reg;
        s4_x_reg    <= sat64((s3_p_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);

        s5_op_reg   <= s4_op_reg;
        s5_sel_reg  <= s4_sel_reg;
        s5_idx_reg  <= s4_idx_reg;
        s5_word_reg <= s4_word_reg;
        s5_x_reg    <= s4_x_reg;
        s5_prod_reg <= $signed({{(P_W - Q_W){s4_x_reg[Q_W-1]}}, s4_x_reg})
                     * $signed({{(P_W - M_W){1'b0}}, m});

        s6_op_reg   <= s5_op_reg;
        s6_sel_reg  <= s5_sel_reg;
        s6_idx_reg  <= s5_idx_reg;
        s6_word_reg <= s5_word_reg;
        s6_x_reg    <= s5_x_reg;
        s6_k_reg    <= k_next;
        s6_cl_reg   <= cl_next;

        s7_op_reg   <= s6_op_reg;
        s7_x_reg    <= s6_x_reg;
        s7_kw_reg   <= KW_W'(s6_k_reg) * KW_W'(segment_width_reg);
        s7_cl_reg   <= s6_cl_reg;

        s8_op_reg   <= s7_op_reg;
        s8_cl_reg   <= s7_cl_reg;
        s8_u_reg    <= u_next;
        s8_c3_reg   <= c3_next;
        s8_c2_reg   <= c2_next;
        s8_c1_reg   <= c1_next;
        s8_a0_reg   <= q_t'(coef_rd[0]);
        s8_a4_reg   <= q_t'(coef_rd[4]);
        s8_bk_reg   <= q_t'(cumul_rd0);
        s8_bk1_reg  <= q_t'(cumul_rd1);

        s9_op_reg   <= s8_op_reg;
        s9_cl_reg   <= s8_cl_reg;
        s9_u_reg    <= s8_u_reg;
        s9_c1_reg   <= s8_c1_reg;
        s9_a0_reg   <= s8_a0_reg;
        s9_a4_reg   <= s8_a4_reg;
        s9_bk_reg   <= s8_bk_reg;
        s9_bk1_reg  <= s8_bk1_reg;
        s9_wu_reg   <= qmul(w_q, s8_u_reg);

        s10_op_reg  <= s9_op_reg;
        s10_cl_reg  <= s9_cl_reg;
        s10_u_reg   <= s9_u_reg;
        s10_a0_reg  <= s9_a0_reg;
        s10_a4_reg  <= s9_a4_reg;
        s10_bk_reg  <= s9_bk_reg;
        s10_bk1_reg <= s9_bk1_reg;
        s10_wu_reg  <= s9_wu_reg;

        s11_op_reg  <= s10_op_reg;
        s11_cl_reg  <= s10_cl_reg;
        s11_u_reg   <= s10_u_reg;
        s11_a4_reg  <= s10_a4_reg;
        s11_bk_reg  <= s10_bk_reg;
        s11_bk1_reg <= s10_bk1_reg;
        s11_wu_reg  <= s10_wu_reg;
        s11_h2_reg  <= s10_h2;

        s12_op_reg   <= s11_op_reg;
        s12_cl_reg   <= s11_cl_reg;
        s12_high_reg <= high_next;
        s12_bk1_reg  <= s11_bk1_reg;
        s12_r1_reg   <= r1_next;

        s13_op_reg  <= s12_op_reg;
        s13_cl_reg  <= s12_cl_reg;
        s13_r2_reg  <= r2_next;

        result_reg  <= qmul(scale, s13_r2_reg);
        clamped_reg <= s13_cl_reg;
    end

    assign done    = done_reg;
    assign result  = result_reg;
    assign clamped = clamped_reg;
endmodule

// File: rtl/pbte_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module pbte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/pbte_mac_stage.sv
// one registered horner step: sat(c + round(a * b))
// depends on pbte_pkg
module pbte_mac_stage (
    input  logic          clk,
    input  pbte_pkg::q_t  a,
    input  pbte_pkg::q_t  b,
    input  pbte_pkg::q_t  c,
    output pbte_pkg::q_t  sum
);
    import pbte_pkg::*;

    q_t sum_reg;

    always_ff @(posedge clk)
    begin
        sum_reg <= sat_add(c, qmul(a, b));
    end

    assign sum = sum_reg;
endmodule
